FILE: hw/rtl/p2x_pkg.sv
// Shared types, constants and the RGB565 blend for the palette 2x upscaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package p2x_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int MAX_ROW_CODES   = 256;
    localparam int MAX_ROWS        = 512;
    localparam int ROW_CODES_W     = 9;
    localparam int FRAME_ROWS_W    = 10;
    localparam int CFG_DATA_W      = 10;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 2);
    localparam int STEP_W          = 3;

    // register indexes on the configuration port
    localparam logic CFG_ROW_CODES  = 1'b0;
    localparam logic CFG_FRAME_ROWS = 1'b1;

    // input function codes
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_PIXEL     = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  entry_addr;
        logic [15:0] entry_color;
        logic [7:0]  pixel_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       row_end;
        logic       frame_end;
    } out_item_t;

    // position of a code within its row
    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_MID,
        KIND_LAST
    } px_kind_t;

    // one queued pixel job
    typedef struct packed {
        logic [15:0] color;
        px_kind_t    kind;
        logic        frame_end;
    } px_job_t;

    // per-channel average, each channel (a + b) >> 1
    function automatic logic [15:0] blend565(input logic [15:0] a, input logic [15:0] b);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] bl;
        r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
        bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
        return {r[5:1], g[6:1], bl[5:1]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/palette_2x_interp_pixel_stream_core.sv
// Top level of the palette lookup / 2x horizontal upscale byte streamer.
// Depends on p2x_pkg, p2x_front, p2x_queue and p2x_back.
//
//   port group   direction  handshake       payload
//   s_*          in         s_valid/s_ready in_item_t  (palette write or pixel code)
//   m_*          out        m_valid/m_ready out_item_t (one display byte)
//   cfg_*        in         cfg_we only     row_codes (index 0), frame_rows (index 1)
//
// Pace: a pixel code yields 2, 4 or 6 bytes (first, middle, last of a row),
//   one byte per cycle out of the back end while m_ready is high and a job
//   is queued, so the output byte register sets the pace.
// Path: accept -> palette read register/push -> queue -> output register.
// Reset: synchronous, active low; clears counters, queue, previous colour and
//   restores row_codes = 160, frame_rows = 240. Palette contents are undefined.
// Stalls: the 4-entry queue lets the front keep taking transactions while the
//   back end waits on m_ready; s_ready drops once the queued jobs plus the job
//   in the palette read stage fill all 4 entries.
`default_nettype none

module palette_2x_interp_pixel_stream_core (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire                           cfg_index,
    input  wire [p2x_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  p2x_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  wire                           m_ready,
    output p2x_pkg::out_item_t            m_data
);
    import p2x_pkg::*;

    logic                q_push, q_pop, q_head_valid;
    px_job_t             q_push_job, q_head_job;
    logic [QUEUE_CW-1:0] q_count;

    // front: classify codes, palette read, row/frame bookkeeping
    p2x_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_count   (q_count),
        .push      (q_push),
        .push_job  (q_push_job)
    );

    // decoupling queue of pixel jobs
    p2x_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .count      (q_count)
    );

    // back: blend and serialize into bytes
    p2x_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("job queue overflow");

    // a full queue must hold off the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == QUEUE_CW'(QUEUE_DEPTH)) |-> !s_ready)
        else $error("input accepted with full queue");

    // frame end only ever lands on the last byte of a row and of a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> (m_data.row_end && m_data.run_last))
        else $error("frame_end without row_end/run_last");

    // a pop always comes with a byte going into the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("job retired without output byte");

endmodule

`default_nettype wire

FILE: hw/rtl/p2x_front.sv
// Front end: accepts transactions, holds the palette and the row/frame counters,
// classifies each code and hands a job to the queue. Depends on p2x_pkg.
`default_nettype none

module p2x_front (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire                                cfg_index,
    input  wire [p2x_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  p2x_pkg::in_item_t                  s_data,
    input  wire [p2x_pkg::QUEUE_CW-1:0]        q_count,
    output logic                               push,
    output p2x_pkg::px_job_t                   push_job
);
    import p2x_pkg::*;

    logic [15:0]             pal_mem [PALETTE_ENTRIES];
    logic [15:0]             rd_data_reg;
    logic                    job_valid_reg;
    px_kind_t                kind_reg, kind_next;
    logic                    fend_reg, fend_next;

    logic [ROW_CODES_W-1:0]  row_codes_reg;
    logic [FRAME_ROWS_W-1:0] frame_rows_reg;
    logic [ROW_CODES_W-1:0]  col_reg, col_next;
    logic [FRAME_ROWS_W-1:0] row_reg, row_next;

    logic [ROW_CODES_W-1:0]  n_codes;
    logic [FRAME_ROWS_W-1:0] n_rows;
    logic [ROW_CODES_W:0]    col_inc;
    logic [FRAME_ROWS_W:0]   row_inc;
    logic                    acc, acc_pix;

    // room for the job in flight plus this one
    assign s_ready = (q_count + QUEUE_CW'(job_valid_reg)) < QUEUE_CW'(QUEUE_DEPTH);
    assign acc     = s_valid && s_ready;
    assign acc_pix = acc && (s_data.func == FUNC_PIXEL);

    always_comb begin
        if (row_codes_reg < ROW_CODES_W'(2)) begin
            n_codes = ROW_CODES_W'(2);
        end else if (row_codes_reg > ROW_CODES_W'(MAX_ROW_CODES)) begin
            n_codes = ROW_CODES_W'(MAX_ROW_CODES);
        end else begin
            n_codes = row_codes_reg;
        end
        if (frame_rows_reg == '0) begin
            n_rows = FRAME_ROWS_W'(1);
        end else if (frame_rows_reg > FRAME_ROWS_W'(MAX_ROWS)) begin
            n_rows = FRAME_ROWS_W'(MAX_ROWS);
        end else begin
            n_rows = frame_rows_reg;
        end

        col_inc   = {1'b0, col_reg} + (ROW_CODES_W+1)'(1);
        row_inc   = {1'b0, row_reg} + (FRAME_ROWS_W+1)'(1);
        col_next  = col_reg;
        row_next  = row_reg;
        kind_next = KIND_FIRST;
        fend_next = 1'b0;

        if (col_reg == '0) begin
            kind_next = KIND_FIRST;
            col_next  = ROW_CODES_W'(1);
        end else if (col_inc >= {1'b0, n_codes}) begin
            kind_next = KIND_LAST;
            col_next  = '0;
            if (row_inc >= {1'b0, n_rows}) begin
                fend_next = 1'b1;
                row_next  = '0;
            end else begin
                row_next  = row_inc[FRAME_ROWS_W-1:0];
            end
        end else begin
            kind_next = KIND_MID;
            col_next  = col_inc[ROW_CODES_W-1:0];
        end
    end

    // palette: one write or one registered read per cycle, only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (acc && (s_data.func == FUNC_PAL_WRITE)) begin
            pal_mem[s_data.entry_addr[PAL_AW-1:0]] <= s_data.entry_color;
        end
        if (acc_pix) begin
            rd_data_reg <= pal_mem[s_data.pixel_code[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_pix) begin
            kind_reg <= kind_next;
            fend_reg <= fend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            row_codes_reg  <= ROW_CODES_W'(160);
            frame_rows_reg <= FRAME_ROWS_W'(240);
        end else begin
            job_valid_reg <= acc_pix;
            if (acc_pix) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ROW_CODES:  row_codes_reg  <= cfg_wdata[ROW_CODES_W-1:0];
                    CFG_FRAME_ROWS: frame_rows_reg <= cfg_wdata[FRAME_ROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign push               = job_valid_reg;
    assign push_job.color     = rd_data_reg;
    assign push_job.kind      = kind_reg;
    assign push_job.frame_end = fend_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/p2x_queue.sv
// Short job queue between front and back end, flop based.
// Depends on p2x_pkg.
`default_nettype none

module p2x_queue (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          push,
    input  p2x_pkg::px_job_t             push_job,
    input  wire                          pop,
    output logic                         head_valid,
    output p2x_pkg::px_job_t             head_job,
    output logic [p2x_pkg::QUEUE_CW-1:0] count
);
    import p2x_pkg::*;

    px_job_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/p2x_back.sv
// Back end: walks the head job byte by byte (average, repeat, pixel), keeps the
// previous colour and drives the output register. Depends on p2x_pkg.
`default_nettype none

module p2x_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 head_valid,
    input  p2x_pkg::px_job_t    head_job,
    output logic                pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output p2x_pkg::out_item_t  m_data
);
    import p2x_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] last_step;
    logic [15:0]       prev_reg;
    logic [15:0]       avg, pix;
    logic              load, emit;
    logic              m_valid_reg;
    out_item_t         m_data_reg, byte_next;

    assign avg  = blend565(prev_reg, head_job.color);
    assign load = !m_valid_reg || m_ready;
    assign emit = load && head_valid;
    assign pop  = emit && (step_reg == last_step);

    always_comb begin
        unique case (head_job.kind)
            KIND_FIRST: last_step = STEP_W'(1);
            KIND_MID:   last_step = STEP_W'(3);
            KIND_LAST:  last_step = STEP_W'(5);
            default:    last_step = STEP_W'(1);
        endcase
        // the final pixel of every job is the looked-up colour itself
        pix = (step_reg >= last_step - STEP_W'(1)) ? head_job.color : avg;
        byte_next.out_byte  = step_reg[0] ? pix[7:0] : pix[15:8];
        byte_next.run_last  = (step_reg == last_step);
        byte_next.row_end   = (step_reg == last_step) && (head_job.kind == KIND_LAST);
        byte_next.frame_end = (step_reg == last_step) && head_job.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= byte_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= head_valid;
            end
            if (pop) begin
                step_reg <= '0;
                prev_reg <= head_job.color;
            end else if (emit) begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sim/tb_palette_2x_interp_pixel_stream_core.sv
// Testbench for palette_2x_interp_pixel_stream_core: palette writes and pixel codes in,
// display bytes out, checked against a local predictor. Depends on p2x_pkg and the RTL.
`timescale 1ns / 100ps

module tb_palette_2x_interp_pixel_stream_core;
    import p2x_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;        // pipeline slack after the last byte
    localparam logic [31:0] RED_MASK   = 32'h0000_f800;
    localparam logic [31:0] GREEN_MASK = 32'h0000_07e0;
    localparam logic [31:0] BLUE_MASK  = 32'h0000_001f;

    // ---------------------------------------------------------------- DUT I/O
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = CFG_ROW_CODES;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    palette_2x_interp_pixel_stream_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------- predictor state
    logic [15:0]          pal_shadow [PALETTE_ENTRIES];
    bit                   pal_written [PALETTE_ENTRIES];
    int                   written_codes[$];     // entries safe to look up
    logic [15:0]          prev_pixel    = '0;
    int                   col_count     = 0;
    int                   row_count     = 0;
    logic [ROW_CODES_W-1:0]  row_codes_q  = 9'd160;
    logic [FRAME_ROWS_W-1:0] frame_rows_q = 10'd240;

    out_item_t expected_bytes[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        idle_pct       = 0;              // idling odds on both sides, percent
    int        stall_left     = 0;

    // per-channel average, each channel (a + b) >> 1; red operands are halved first
    function automatic logic [15:0] avg_rgb565(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] r, g, bl;
        r  = ((({16'h0, a} & RED_MASK) >> 1) + (({16'h0, b} & RED_MASK) >> 1)) & RED_MASK;
        g  = ((({16'h0, a} & GREEN_MASK) + ({16'h0, b} & GREEN_MASK)) >> 1) & GREEN_MASK;
        bl = ((({16'h0, a} & BLUE_MASK) + ({16'h0, b} & BLUE_MASK)) >> 1) & BLUE_MASK;
        return 16'(r | g | bl);
    endfunction

    // two bytes per pixel, high first; flags only on the low byte of the last pixel
    function automatic void queue_pixel(input logic [15:0] c, input bit last,
                                        input bit row_done, input bit frame_done);
        out_item_t hi, lo;
        hi = '0;
        hi.out_byte  = c[15:8];
        lo.out_byte  = c[7:0];
        lo.run_last  = last;
        lo.row_end   = last & row_done;
        lo.frame_end = last & frame_done;
        expected_bytes.push_back(hi);
        expected_bytes.push_back(lo);
    endfunction

    // expected bytes for one accepted transaction
    function automatic void predict_display_bytes(input in_item_t t);
        int          n_codes, n_rows;
        logic [15:0] cur, avg;
        bit          row_done, frame_done;
        if (t.func == FUNC_PAL_WRITE) begin
            pal_shadow[t.entry_addr] = t.entry_color;
            if (!pal_written[t.entry_addr]) begin
                pal_written[t.entry_addr] = 1'b1;
                written_codes.push_back(int'(t.entry_addr));
            end
            return;
        end
        // out-of-range lengths clamp
        n_codes = int'(row_codes_q);
        if (n_codes < 2) n_codes = 2;
        if (n_codes > MAX_ROW_CODES) n_codes = MAX_ROW_CODES;
        n_rows = int'(frame_rows_q);
        if (n_rows < 1) n_rows = 1;
        if (n_rows > MAX_ROWS) n_rows = MAX_ROWS;

        cur        = pal_shadow[t.pixel_code];
        row_done   = (col_count != 0) && (col_count + 1 >= n_codes);
        frame_done = row_done && (row_count + 1 >= n_rows);

        if (col_count == 0) begin
            queue_pixel(cur, 1'b1, 1'b0, 1'b0);
            col_count = 1;
        end else begin
            avg = avg_rgb565(prev_pixel, cur);
            queue_pixel(avg, 1'b0, 1'b0, 1'b0);
            if (row_done) queue_pixel(avg, 1'b0, 1'b0, 1'b0);   // row end repeats it
            queue_pixel(cur, 1'b1, row_done, frame_done);
            col_count++;
        end
        prev_pixel = cur;

        if (row_done) begin
            col_count = 0;
            row_count = frame_done ? 0 : row_count + 1;
        end
    endfunction

    // ----------------------------------------------------------- result side
    // m_ready: random stall bursts while idle_pct is nonzero
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every accepted byte against the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected byte: expected none, actual %h last=%b row=%b frame=%b",
                         $time, m_data.out_byte, m_data.run_last, m_data.row_end,
                         m_data.frame_end);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data != want) begin
                    mismatch_count++;
                    $display("%0t: mismatch: expected %h last=%b row=%b frame=%b, actual %h last=%b row=%b frame=%b",
                             $time, want.out_byte, want.run_last, want.row_end, want.frame_end,
                             m_data.out_byte, m_data.run_last, m_data.row_end,
                             m_data.frame_end);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_palette_2x_interp_pixel_stream_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------ input side
    // one transaction; valid is only lowered for an idle gap, never in the accept step
    task automatic send_transaction(input in_item_t t);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        predict_display_bytes(t);
    endtask

    task automatic send_palette_write(input logic [7:0] addr, input logic [15:0] color);
        in_item_t t;
        t.func        = FUNC_PAL_WRITE;
        t.entry_addr  = addr;
        t.entry_color = color;
        t.pixel_code  = 8'($urandom);       // ignored by the block
        send_transaction(t);
    endtask

    task automatic send_code(input logic [7:0] code);
        in_item_t t;
        t.func        = FUNC_PIXEL;
        t.entry_addr  = 8'($urandom);       // ignored
        t.entry_color = 16'($urandom);      // ignored
        t.pixel_code  = code;
        send_transaction(t);
    endtask

    // wait for the block to go idle: no bytes owed, then pipeline slack
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // only while idle; a trailing wait with cfg_we low so back-to-back writes never share a step
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROW_CODES) row_codes_q = val[ROW_CODES_W-1:0];
        else                      frame_rows_q = val[FRAME_ROWS_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_lengths(input int codes, input int rows);
        settle();
        write_reg(CFG_ROW_CODES, CFG_DATA_W'(codes));
        write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(rows));
    endtask

    // ------------------------------------------------------------ test tasks
    task automatic test_palette_load();
        idle_pct = 30;
        send_palette_write(8'h00, 16'h0000);
        send_palette_write(8'hff, 16'hffff);
        send_palette_write(8'h55, 16'hf800);
        send_palette_write(8'haa, 16'h07e0);
        send_palette_write(8'h0f, 16'h001f);
        send_palette_write(8'hf0, 16'h0821);   // low bit of each channel set
    endtask

    // two- and three-code rows: first, middle and last positions, frame end
    task automatic test_short_rows();
        set_lengths(2, 1);
        send_code(8'hff);
        send_code(8'h00);
        send_code(8'hf0);
        send_code(8'hf0);   // odd + odd red: the average keeps the low bit
        send_code(8'h55);
        send_code(8'haa);
        set_lengths(3, 2);
        send_code(8'h55);
        send_code(8'hff);
        send_code(8'h0f);
        send_code(8'haa);
        send_code(8'h00);
        send_code(8'hf0);
    endtask

    // lengths of zero and beyond the maximum
    task automatic test_length_clamp();
        set_lengths(0, 0);
        send_code(8'hff);
        send_code(8'h0f);
        set_lengths(511, 1023);
        send_code(8'haa);
        send_code(8'h55);
        send_code(8'hf0);
    endtask

    // shortened lengths while mid-row and mid-frame end the row/frame at once
    task automatic test_shorten_mid_row();
        settle();
        write_reg(CFG_ROW_CODES, CFG_DATA_W'(2));
        send_code(8'h00);
        settle();
        write_reg(CFG_FRAME_ROWS, CFG_DATA_W'(1));
        send_code(8'hff);
        send_code(8'h55);
    endtask

    // random content: mostly codes from written entries, some palette rewrites
    task automatic run_random_phase(input int codes, input int rows, input int n_codes,
                                    input int idle, input int write_pct);
        int sent;
        sent = 0;
        set_lengths(codes, rows);
        idle_pct = idle;
        while (sent < n_codes) begin
            if ($urandom_range(0, 99) < write_pct) begin
                send_palette_write(8'($urandom), 16'($urandom));
            end else begin
                send_code(8'(written_codes[$urandom_range(0, written_codes.size() - 1)]));
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        run_random_phase(5, 3, 25, 30, 25);
        run_random_phase(2, 2, 12, 45, 20);
        run_random_phase(256, 512, 256, 25, 10);   // full-width row
    endtask

    // last stretch with no idling on either side
    task automatic test_unstalled_tail();
        run_random_phase(4, 2, 16, 0, 15);
    endtask

    // ------------------------------------------------------------- sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_palette_load();
        test_short_rows();
        test_length_clamp();
        test_shorten_mid_row();
        test_random_phases();
        test_unstalled_tail();
        settle();

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("tb_palette_2x_interp_pixel_stream_core: PASS");
        else
            $display("tb_palette_2x_interp_pixel_stream_core: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/p2x_pkg.sv
hw/rtl/p2x_front.sv
hw/rtl/p2x_queue.sv
hw/rtl/p2x_back.sv
hw/rtl/palette_2x_interp_pixel_stream_core.sv
sim/tb_palette_2x_interp_pixel_stream_core.sv
